>>> hw/rtl/tbsa_pkg.sv
// ----------------------------------------------------------------------------
// tbsa_pkg: shared constants for the tagged bitmap slot allocator
// Slot, count and key widths, operation codes and controller state codes.
// ----------------------------------------------------------------------------
package tbsa_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KEY_W  = 48;
  localparam int FUNC_W = 3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FN_TAKE      = 3'd0;
  localparam func_t FN_AUTO      = 3'd1;
  localparam func_t FN_FREE      = 3'd2;
  localparam func_t FN_FREE_OWN  = 3'd3;
  localparam func_t FN_QRY_SLOT  = 3'd4;
  localparam func_t FN_QRY_OWNER = 3'd5;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_SCAN = 2'd1;
  localparam logic [ST_W-1:0] ST_FIN  = 2'd2;

  localparam cnt_t SLOTS_CNT = cnt_t'(SLOTS);

endpackage

>>> hw/rtl/tagged_bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// tagged_bitmap_slot_allocator
// Slot allocator over an occupancy bitmap with an owner tag memory.
// ----------------------------------------------------------------------------
// Operation: every accepted beat sweeps the tag memory once, over the lim
//   slots below lim = min(slots_in_use, 256), and yields one result beat; a
//   new beat is taken only after the finish step, while a result may wait.
// Sweep: the single tag memory read port delivers one slot per cycle.
// Reset: rst_n (synchronous, active low) clears all occupancy flip-flops at
//   once and sets slots_in_use to 256; no clearing pass.
module tagged_bitmap_slot_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tbsa_pkg::CNT_W-1:0] cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tbsa_pkg::func_t           in_func,
  input  tbsa_pkg::slot_t           in_slot,
  input  tbsa_pkg::key_t            in_owner_key,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_ok,
  output tbsa_pkg::slot_t           out_slot_out,
  output logic                      out_occupied,
  output tbsa_pkg::key_t            out_owner_out,
  output tbsa_pkg::cnt_t            out_free_count,
  output tbsa_pkg::cnt_t            out_taken_count
);

  // Register and derived slot limit
  tbsa_pkg::cnt_t cfg_r;
  tbsa_pkg::cnt_t lim;

  // Controller
  logic [tbsa_pkg::ST_W-1:0] state_r, state_nxt;
  logic in_fire, fin_fire;

  // Captured request
  tbsa_pkg::func_t func_r;
  tbsa_pkg::slot_t slot_r;
  tbsa_pkg::key_t  key_r;

  // Sweep
  tbsa_pkg::cnt_t  idx_r;
  logic            issue;
  logic            rd_v_r;
  tbsa_pkg::slot_t rd_idx_r;
  tbsa_pkg::key_t  tag_q_r;
  logic            occ_q_r;
  tbsa_pkg::cnt_t  count_r;
  logic            fnd_free_r, fnd_own_r;
  tbsa_pkg::slot_t free_hit_r, own_hit_r;
  tbsa_pkg::key_t  slot_tag_r;
  logic            slot_occ_r;
  logic            rd_occ;

  // Occupancy bits in flip-flops, owner tags in memory
  logic [tbsa_pkg::SLOTS-1:0] occ_r;
  tbsa_pkg::key_t             tag_mem [tbsa_pkg::SLOTS];

  // Finish-step results
  logic            in_range, occ_s;
  logic            res_ok, res_occ;
  tbsa_pkg::slot_t res_slot;
  tbsa_pkg::key_t  res_owner;
  tbsa_pkg::cnt_t  res_taken;
  logic            set_en, clr_en;
  tbsa_pkg::slot_t mod_addr;

  // Output register
  logic            out_valid_r;
  logic            ok_r, occupied_r;
  tbsa_pkg::slot_t slot_out_r;
  tbsa_pkg::key_t  owner_out_r;
  tbsa_pkg::cnt_t  free_cnt_r, taken_cnt_r;

  // Writes must only arrive while idle (the block does not enforce this); the port never pushes back.
  assign cfg_ready = 1'b1;
  assign lim = (cfg_r > tbsa_pkg::SLOTS_CNT) ? tbsa_pkg::SLOTS_CNT : cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tbsa_pkg::SLOTS_CNT;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // Take a new request only when the sweep is free; a result may still wait.
  assign in_stall = (state_r != tbsa_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign fin_fire = (state_r == tbsa_pkg::ST_FIN) && (!out_valid_r || !out_stall);
  assign issue    = (state_r == tbsa_pkg::ST_SCAN) && (idx_r < lim);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbsa_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = tbsa_pkg::ST_SCAN;
      end
      tbsa_pkg::ST_SCAN: begin
        // done once every slot below the limit is issued and the last read drained
        if (!issue && !rd_v_r) state_nxt = tbsa_pkg::ST_FIN;
      end
      tbsa_pkg::ST_FIN: begin
        if (fin_fire) state_nxt = tbsa_pkg::ST_IDLE;
      end
      default: state_nxt = tbsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbsa_pkg::ST_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
    end
  end

  // Latch the request and reset the sweep accumulators on accept
  assign rd_occ = occ_q_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r     <= in_func;
      slot_r     <= in_slot;
      key_r      <= in_owner_key;
      idx_r      <= '0;
      count_r    <= '0;
      fnd_free_r <= 1'b0;
      fnd_own_r  <= 1'b0;
      free_hit_r <= '0;
      own_hit_r  <= '0;
      slot_tag_r <= '0;
      slot_occ_r <= 1'b0;
    end else begin
      if (issue) begin
        idx_r    <= idx_r + tbsa_pkg::cnt_t'(1);
        rd_idx_r <= idx_r[tbsa_pkg::SLOT_W-1:0];
      end
      if (rd_v_r) begin
        // count taken slots and note the first free and first matching ones
        count_r <= count_r + tbsa_pkg::cnt_t'(rd_occ);
        if (!fnd_free_r && !rd_occ) begin
          fnd_free_r <= 1'b1;
          free_hit_r <= rd_idx_r;
        end
        if (!fnd_own_r && rd_occ && (tag_q_r == key_r)) begin
          fnd_own_r <= 1'b1;
          own_hit_r <= rd_idx_r;
        end
        if (rd_idx_r == slot_r) begin
          slot_tag_r <= tag_q_r;
          slot_occ_r <= rd_occ;
        end
      end
    end
  end

  // Tag memory: one write port, one registered read port; the occupancy bit
  // of the same slot is registered alongside
  always_ff @(posedge clk) begin
    if (issue) begin
      tag_q_r <= tag_mem[idx_r[tbsa_pkg::SLOT_W-1:0]];
      occ_q_r <= occ_r[idx_r[tbsa_pkg::SLOT_W-1:0]];
    end
    if (fin_fire && set_en) tag_mem[mod_addr] <= key_r;
  end

  // Finish step: decide the operation's effect from the sweep summary
  assign in_range = ({1'b0, slot_r} < lim);
  assign occ_s    = slot_occ_r;

  always_comb begin
    res_ok    = 1'b0;
    res_slot  = '0;
    res_occ   = 1'b0;
    res_owner = '0;
    res_taken = count_r;
    set_en    = 1'b0;
    clr_en    = 1'b0;
    mod_addr  = slot_r;
    case (func_r)
      tbsa_pkg::FN_TAKE: begin
        if (in_range && !occ_s) begin
          res_ok    = 1'b1;
          res_slot  = slot_r;
          res_taken = count_r + tbsa_pkg::cnt_t'(1);
          set_en    = 1'b1;
        end
      end
      tbsa_pkg::FN_AUTO: begin
        mod_addr = free_hit_r;
        if (fnd_free_r) begin
          res_ok    = 1'b1;
          res_slot  = free_hit_r;
          res_taken = count_r + tbsa_pkg::cnt_t'(1);
          set_en    = 1'b1;
        end
      end
      tbsa_pkg::FN_FREE: begin
        // freeing a slot that is already free still succeeds
        if (in_range) begin
          res_ok    = 1'b1;
          res_slot  = slot_r;
          res_taken = count_r - tbsa_pkg::cnt_t'(occ_s);
          clr_en    = 1'b1;
        end
      end
      tbsa_pkg::FN_FREE_OWN: begin
        mod_addr = own_hit_r;
        if (fnd_own_r) begin
          res_ok    = 1'b1;
          res_slot  = own_hit_r;
          res_taken = count_r - tbsa_pkg::cnt_t'(1);
          clr_en    = 1'b1;
        end
      end
      tbsa_pkg::FN_QRY_SLOT: begin
        // out of range reads as taken with no owner
        if (in_range) begin
          res_ok    = 1'b1;
          res_slot  = slot_r;
          res_occ   = occ_s;
          res_owner = occ_s ? slot_tag_r : '0;
        end else begin
          res_occ = 1'b1;
        end
      end
      tbsa_pkg::FN_QRY_OWNER: begin
        if (fnd_own_r) begin
          res_ok   = 1'b1;
          res_slot = own_hit_r;
        end
      end
      default: begin
        // unused codes: report counts only
      end
    endcase
  end

  // Occupancy bits; reset clears them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (fin_fire) begin
      if (set_en) occ_r[mod_addr] <= 1'b1;
      if (clr_en) occ_r[mod_addr] <= 1'b0;
    end
  end

  // Result register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      ok_r        <= res_ok;
      slot_out_r  <= res_slot;
      occupied_r  <= res_occ;
      owner_out_r <= res_owner;
      taken_cnt_r <= res_taken;
      free_cnt_r  <= lim - res_taken;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_slot_out    = slot_out_r;
  assign out_occupied    = occupied_r;
  assign out_owner_out   = owner_out_r;
  assign out_free_count  = free_cnt_r;
  assign out_taken_count = taken_cnt_r;

endmodule
